### design/eul_pkg.sv
// ----------------------------------------------------------------------------
// eul_pkg
// shared types and constants for the euler angle to rotation matrix pipeline
// ----------------------------------------------------------------------------
package eul_pkg;

  localparam int unsigned XW           = 32;  // cordic x / y, Q30
  localparam int unsigned ZW           = 34;  // cordic residual angle, Q29
  localparam int unsigned DW           = 17;  // degree magnitude before clamp
  localparam int unsigned ATAN_ENTRIES = 24;

  localparam logic signed [ZW-1:0] PI_Q29      = 34'sd1686629713;
  localparam logic signed [ZW-1:0] HALF_PI_Q29 = 34'sd843314857;
  localparam logic signed [XW-1:0] GAIN_Q30    = 32'sd652032874;
  localparam logic [31:0]          DEG_K       = 32'd3003948965;
  localparam logic [DW-1:0]        DEG_LIMIT   = 17'd18000;

  localparam logic signed [ZW-1:0] ATAN_Q29 [ATAN_ENTRIES] = '{
    34'sd421657428, 34'sd248918915, 34'sd131521918, 34'sd66762579,
    34'sd33510843,  34'sd16771758,  34'sd8387925,   34'sd4194219,
    34'sd2097141,   34'sd1048575,   34'sd524288,    34'sd262144,
    34'sd131072,    34'sd65536,     34'sd32768,     34'sd16384,
    34'sd8192,      34'sd4096,      34'sd2048,      34'sd1024,
    34'sd512,       34'sd256,       34'sd128,       34'sd64
  };

  // one cordic lane
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } lane_t;

  // sideband that travels with the cordic lanes
  typedef struct packed {
    logic [2:0]         flip;
    logic [2:0]         dneg;
    logic [2:0][DW-1:0] dmag;
  } side_t;

endpackage

### design/eul_cordic_stage.sv
// ----------------------------------------------------------------------------
// eul_cordic_stage
// one registered rotation-mode cordic iteration for one lane
// ----------------------------------------------------------------------------
module eul_cordic_stage #(
  parameter int unsigned STAGE = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  eul_pkg::lane_t lane_i,
  output eul_pkg::lane_t lane_o
);
  import eul_pkg::*;

  lane_t lane_d, lane_q;
  logic signed [XW-1:0] xs, ys;

  always_comb begin
    xs = lane_i.x >>> STAGE;
    ys = lane_i.y >>> STAGE;
    if (!lane_i.z[ZW-1]) begin
      lane_d.x = lane_i.x - ys;
      lane_d.y = lane_i.y + xs;
      lane_d.z = lane_i.z - ATAN_Q29[STAGE];
    end else begin
      lane_d.x = lane_i.x + ys;
      lane_d.y = lane_i.y - xs;
      lane_d.z = lane_i.z + ATAN_Q29[STAGE];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

### design/euler_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// roll / pitch / yaw (Q3.13 rad) to zyx direction cosine matrix (Q1.14)
// ----------------------------------------------------------------------------
// Takes one angle set per beat and returns the nine body-from-navigation
// matrix entries plus each angle in hundredths of a degree. The block is a
// fixed pipeline: one range-reduction stage, CORDIC_STAGES cordic stages (one
// iteration each, three lanes side by side), then flip, first product, round,
// second product, sum and round/clamp stages. A new beat is taken every cycle
// while in_ready_o is high. Every stage has its own valid bit and stalls only
// when the stage after it is full, so an output stall fills the pipeline
// before in_ready_o drops.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix #(
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned OUT_FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] roll_angle_i,
  input  logic signed [15:0] pitch_angle_i,
  input  logic signed [15:0] yaw_angle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] m_ax_o,
  output logic signed [15:0] m_ay_o,
  output logic signed [15:0] m_az_o,
  output logic signed [15:0] m_bx_o,
  output logic signed [15:0] m_by_o,
  output logic signed [15:0] m_bz_o,
  output logic signed [15:0] m_cx_o,
  output logic signed [15:0] m_cy_o,
  output logic signed [15:0] m_cz_o,
  output logic signed [15:0] roll_centideg_o,
  output logic signed [15:0] pitch_centideg_o,
  output logic signed [15:0] yaw_centideg_o
);
  import eul_pkg::*;

  localparam int unsigned CS = CORDIC_STAGES;
  localparam int unsigned SH = 60 - OUT_FRAC_BITS;          // Q60 to output
  localparam logic signed [63:0] RND = 64'sd1 <<< (SH - 1);
  localparam logic signed [63:0] LIM = 64'sd1 <<< OUT_FRAC_BITS;
  localparam logic signed [63:0] HALF30 = 64'sd1 <<< 29;

  // ready chain: stage k may load when it is empty or the next one loads
  logic [CS+1:0] rdy;
  logic rdy_f, rdy_m1, rdy_r1, rdy_m2, rdy_s, rdy_o;
  logic vld_q [CS+1];
  logic vld_f_q, vld_m1_q, vld_r1_q, vld_m2_q, vld_s_q, vld_o_q;

  assign rdy_o  = !vld_o_q  || out_ready_i;
  assign rdy_s  = !vld_s_q  || rdy_o;
  assign rdy_m2 = !vld_m2_q || rdy_s;
  assign rdy_r1 = !vld_r1_q || rdy_m2;
  assign rdy_m1 = !vld_m1_q || rdy_r1;
  assign rdy_f  = !vld_f_q  || rdy_m1;

  always_comb begin
    rdy[CS+1] = rdy_f;
    for (int k = CS; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_o_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= CS; k++) vld_q[k] <= 1'b0;
      vld_f_q  <= 1'b0;
      vld_m1_q <= 1'b0;
      vld_r1_q <= 1'b0;
      vld_m2_q <= 1'b0;
      vld_s_q  <= 1'b0;
      vld_o_q  <= 1'b0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k <= CS; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
      if (rdy_f)  vld_f_q  <= vld_q[CS];
      if (rdy_m1) vld_m1_q <= vld_f_q;
      if (rdy_r1) vld_r1_q <= vld_m1_q;
      if (rdy_m2) vld_m2_q <= vld_r1_q;
      if (rdy_s)  vld_s_q  <= vld_m2_q;
      if (rdy_o)  vld_o_q  <= vld_s_q;
    end
  end

  // --------------------------------------------------------------------------
  // range reduction and degree product
  // --------------------------------------------------------------------------
  logic signed [15:0] ang [3];
  lane_t lane0_d [3];
  lane_t lane0_q [3];
  side_t side0_d;
  side_t side_q [CS+1];

  assign ang[0] = roll_angle_i;
  assign ang[1] = pitch_angle_i;
  assign ang[2] = yaw_angle_i;

  always_comb begin
    logic signed [ZW-1:0] z0;
    logic [16:0] amag;
    logic [48:0] dp;
    for (int l = 0; l < 3; l++) begin
      z0 = {{2{ang[l][15]}}, ang[l], 16'b0};
      lane0_d[l].x = GAIN_Q30;
      lane0_d[l].y = '0;
      side0_d.flip[l] = 1'b0;
      if (z0 > HALF_PI_Q29) begin
        z0 = z0 - PI_Q29;
        side0_d.flip[l] = 1'b1;
      end else if (z0 < -HALF_PI_Q29) begin
        z0 = z0 + PI_Q29;
        side0_d.flip[l] = 1'b1;
      end
      lane0_d[l].z = z0;
      amag = ang[l][15] ? (17'd0 - {ang[l][15], ang[l]}) : {1'b0, ang[l]};
      dp = 49'(amag) * 49'(DEG_K);
      side0_d.dmag[l] = dp[48:32];
      side0_d.dneg[l] = ang[l][15];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      lane0_q    <= lane0_d;
      side_q[0]  <= side0_d;
    end
    for (int k = 1; k <= CS; k++) begin
      if (rdy[k]) side_q[k] <= side_q[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // cordic iterations, three lanes per stage
  // --------------------------------------------------------------------------
  lane_t lane_w [CS+1][3];

  for (genvar l = 0; l < 3; l++) begin : g_lane0
    assign lane_w[0][l] = lane0_q[l];
  end

  for (genvar k = 0; k < CS; k++) begin : g_stage
    for (genvar l = 0; l < 3; l++) begin : g_lane
      eul_cordic_stage #(
        .STAGE(k)
      ) u_stage (
        .clk_i (clk_i),
        .en_i  (rdy[k+1]),
        .lane_i(lane_w[k][l]),
        .lane_o(lane_w[k+1][l])
      );
    end
  end

  // --------------------------------------------------------------------------
  // quadrant flip and degree clamp
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] sin_q [3];
  logic signed [XW-1:0] cos_q [3];
  logic signed [15:0]   deg_f_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy_f) begin
      for (int l = 0; l < 3; l++) begin
        logic [DW-1:0] dq;
        dq = (side_q[CS].dmag[l] > DEG_LIMIT) ? DEG_LIMIT : side_q[CS].dmag[l];
        sin_q[l] <= side_q[CS].flip[l] ? -lane_w[CS][l].y : lane_w[CS][l].y;
        cos_q[l] <= side_q[CS].flip[l] ? -lane_w[CS][l].x : lane_w[CS][l].x;
        deg_f_q[l] <= side_q[CS].dneg[l] ? -$signed(dq[15:0]) : $signed(dq[15:0]);
      end
    end
  end

  // lane order: roll, pitch, yaw
  logic signed [XW-1:0] sr, cr, sp, cp, sy, cy;
  assign sr = sin_q[0];
  assign cr = cos_q[0];
  assign sp = sin_q[1];
  assign cp = cos_q[1];
  assign sy = sin_q[2];
  assign cy = cos_q[2];

  // --------------------------------------------------------------------------
  // first products
  // --------------------------------------------------------------------------
  logic signed [63:0] srsp_m1_q, crsp_m1_q, cpcy_m1_q, cpsy_m1_q, srcp_m1_q;
  logic signed [63:0] crcp_m1_q, crsy_m1_q, crcy_m1_q, srsy_m1_q, srcy_m1_q;
  logic signed [XW-1:0] sp_m1_q, sy_m1_q, cy_m1_q;
  logic signed [15:0]   deg_m1_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy_m1) begin
      srsp_m1_q <= 64'(sr) * 64'(sp);
      crsp_m1_q <= 64'(cr) * 64'(sp);
      cpcy_m1_q <= 64'(cp) * 64'(cy);
      cpsy_m1_q <= 64'(cp) * 64'(sy);
      srcp_m1_q <= 64'(sr) * 64'(cp);
      crcp_m1_q <= 64'(cr) * 64'(cp);
      crsy_m1_q <= 64'(cr) * 64'(sy);
      crcy_m1_q <= 64'(cr) * 64'(cy);
      srsy_m1_q <= 64'(sr) * 64'(sy);
      srcy_m1_q <= 64'(sr) * 64'(cy);
      sp_m1_q   <= sp;
      sy_m1_q   <= sy;
      cy_m1_q   <= cy;
      deg_m1_q  <= deg_f_q;
    end
  end

  // --------------------------------------------------------------------------
  // round the two partial products back to Q30
  // --------------------------------------------------------------------------
  logic signed [63:0] srsp_rs, crsp_rs;
  logic signed [33:0] srsp_r1_q, crsp_r1_q;
  logic signed [63:0] cpcy_r1_q, cpsy_r1_q, srcp_r1_q, crcp_r1_q;
  logic signed [63:0] crsy_r1_q, crcy_r1_q, srsy_r1_q, srcy_r1_q;
  logic signed [XW-1:0] sp_r1_q, sy_r1_q, cy_r1_q;
  logic signed [15:0]   deg_r1_q [3];

  assign srsp_rs = (srsp_m1_q + HALF30) >>> 30;
  assign crsp_rs = (crsp_m1_q + HALF30) >>> 30;

  always_ff @(posedge clk_i) begin
    if (rdy_r1) begin
      srsp_r1_q <= srsp_rs[33:0];
      crsp_r1_q <= crsp_rs[33:0];
      cpcy_r1_q <= cpcy_m1_q;
      cpsy_r1_q <= cpsy_m1_q;
      srcp_r1_q <= srcp_m1_q;
      crcp_r1_q <= crcp_m1_q;
      crsy_r1_q <= crsy_m1_q;
      crcy_r1_q <= crcy_m1_q;
      srsy_r1_q <= srsy_m1_q;
      srcy_r1_q <= srcy_m1_q;
      sp_r1_q   <= sp_m1_q;
      sy_r1_q   <= sy_m1_q;
      cy_r1_q   <= cy_m1_q;
      deg_r1_q  <= deg_m1_q;
    end
  end

  // --------------------------------------------------------------------------
  // second products
  // --------------------------------------------------------------------------
  logic signed [65:0] srspcy_w, srspsy_w, crspcy_w, crspsy_w;
  logic signed [63:0] srspcy_q, srspsy_q, crspcy_q, crspsy_q;
  logic signed [63:0] cpcy_m2_q, cpsy_m2_q, srcp_m2_q, crcp_m2_q;
  logic signed [63:0] crsy_m2_q, crcy_m2_q, srsy_m2_q, srcy_m2_q;
  logic signed [XW-1:0] sp_m2_q;
  logic signed [15:0]   deg_m2_q [3];

  assign srspcy_w = 66'(srsp_r1_q) * 66'(cy_r1_q);
  assign srspsy_w = 66'(srsp_r1_q) * 66'(sy_r1_q);
  assign crspcy_w = 66'(crsp_r1_q) * 66'(cy_r1_q);
  assign crspsy_w = 66'(crsp_r1_q) * 66'(sy_r1_q);

  always_ff @(posedge clk_i) begin
    if (rdy_m2) begin
      srspcy_q  <= srspcy_w[63:0];
      srspsy_q  <= srspsy_w[63:0];
      crspcy_q  <= crspcy_w[63:0];
      crspsy_q  <= crspsy_w[63:0];
      cpcy_m2_q <= cpcy_r1_q;
      cpsy_m2_q <= cpsy_r1_q;
      srcp_m2_q <= srcp_r1_q;
      crcp_m2_q <= crcp_r1_q;
      crsy_m2_q <= crsy_r1_q;
      crcy_m2_q <= crcy_r1_q;
      srsy_m2_q <= srsy_r1_q;
      srcy_m2_q <= srcy_r1_q;
      sp_m2_q   <= sp_r1_q;
      deg_m2_q  <= deg_r1_q;
    end
  end

  // --------------------------------------------------------------------------
  // matrix sums in Q60, entry order ax ay az bx by bz cx cy cz
  // --------------------------------------------------------------------------
  logic signed [63:0] sum_q [9];
  logic signed [63:0] spx;
  logic signed [15:0] deg_s_q [3];

  assign spx = 64'(sp_m2_q);

  always_ff @(posedge clk_i) begin
    if (rdy_s) begin
      sum_q[0] <= cpcy_m2_q;
      sum_q[1] <= srspcy_q - crsy_m2_q;
      sum_q[2] <= srsy_m2_q + crspcy_q;
      sum_q[3] <= cpsy_m2_q;
      sum_q[4] <= crcy_m2_q + srspsy_q;
      sum_q[5] <= crspsy_q - srcy_m2_q;
      sum_q[6] <= -(spx <<< 30);
      sum_q[7] <= srcp_m2_q;
      sum_q[8] <= crcp_m2_q;
      deg_s_q  <= deg_m2_q;
    end
  end

  // --------------------------------------------------------------------------
  // round to nearest (ties up), clamp, output register
  // --------------------------------------------------------------------------
  logic signed [15:0] ent_d [9];
  logic signed [15:0] ent_q [9];
  logic signed [15:0] deg_o_q [3];

  always_comb begin
    logic signed [63:0] r;
    for (int e = 0; e < 9; e++) begin
      r = (sum_q[e] + RND) >>> SH;
      if (r > LIM) r = LIM;
      if (r < -LIM) r = -LIM;
      ent_d[e] = r[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o) begin
      ent_q   <= ent_d;
      deg_o_q <= deg_s_q;
    end
  end

  assign m_ax_o = ent_q[0];
  assign m_ay_o = ent_q[1];
  assign m_az_o = ent_q[2];
  assign m_bx_o = ent_q[3];
  assign m_by_o = ent_q[4];
  assign m_bz_o = ent_q[5];
  assign m_cx_o = ent_q[6];
  assign m_cy_o = ent_q[7];
  assign m_cz_o = ent_q[8];
  assign roll_centideg_o  = deg_o_q[0];
  assign pitch_centideg_o = deg_o_q[1];
  assign yaw_centideg_o   = deg_o_q[2];

endmodule

### tb/tb_euler_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// tb_euler_to_rotation_matrix
// self-checking bench for the euler angle to rotation matrix pipeline
// ----------------------------------------------------------------------------
// A queue of angle sets, directed corners first and random sets after, feeds a
// clocked driver with random gaps. Every accepted beat is run through a local
// bit-exact cordic / product model, and the twelve predicted fields wait in a
// queue. A clocked monitor with random back-pressure compares each output beat
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_euler_to_rotation_matrix;
  import eul_pkg::*;

  localparam int unsigned STAGES    = 16;
  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned N_FIELDS  = 12;
  localparam int unsigned N_RANDOM  = 400;
  localparam int unsigned DRAIN_CYC = 2 * (STAGES + 7);

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } angles_t;

  // twelve result fields, index order: nine matrix entries, then three angles
  typedef logic [N_FIELDS-1:0][15:0] dcm_beat_t;

  string field_name [N_FIELDS] = '{
    "m_ax", "m_ay", "m_az", "m_bx", "m_by", "m_bz", "m_cx", "m_cy", "m_cz",
    "roll_centideg", "pitch_centideg", "yaw_centideg"
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] roll_angle_i = '0;
  logic signed [15:0] pitch_angle_i = '0;
  logic signed [15:0] yaw_angle_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] m_ax_o, m_ay_o, m_az_o, m_bx_o, m_by_o, m_bz_o;
  logic signed [15:0] m_cx_o, m_cy_o, m_cz_o;
  logic signed [15:0] roll_centideg_o, pitch_centideg_o, yaw_centideg_o;

  angles_t   angle_queue [$];
  dcm_beat_t dcm_expected [$];
  int        err_cnt = 0;
  int        sent_cnt = 0;
  int        pause_at_a = -1;
  int        pause_at_b = -1;

  always #5 clk_i = ~clk_i;

  euler_to_rotation_matrix #(
    .CORDIC_STAGES (STAGES),
    .OUT_FRAC_BITS (FRAC_BITS)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .roll_angle_i     (roll_angle_i),
    .pitch_angle_i    (pitch_angle_i),
    .yaw_angle_i      (yaw_angle_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .m_ax_o           (m_ax_o),
    .m_ay_o           (m_ay_o),
    .m_az_o           (m_az_o),
    .m_bx_o           (m_bx_o),
    .m_by_o           (m_by_o),
    .m_bz_o           (m_bz_o),
    .m_cx_o           (m_cx_o),
    .m_cy_o           (m_cy_o),
    .m_cz_o           (m_cz_o),
    .roll_centideg_o  (roll_centideg_o),
    .pitch_centideg_o (pitch_centideg_o),
    .yaw_centideg_o   (yaw_centideg_o)
  );

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // round to nearest, ties toward plus infinity, arithmetic shift
  function automatic longint round_sh(longint v, int unsigned s);
    if (s == 0) return v;
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // rotation-mode cordic with quadrant fold, sine and cosine in Q30
  function automatic void cordic_sin_cos(input logic signed [15:0] ang,
                                         output longint s, output longint c);
    longint z, x, y, nx;
    bit     flip;
    z    = longint'(ang) * 65536;
    x    = longint'(GAIN_Q30);
    y    = 0;
    flip = 1'b0;
    // fold angles beyond a quarter turn back by half a turn
    if (z > longint'(HALF_PI_Q29)) begin
      z    = z - longint'(PI_Q29);
      flip = 1'b1;
    end else if (z < -longint'(HALF_PI_Q29)) begin
      z    = z + longint'(PI_Q29);
      flip = 1'b1;
    end
    for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(ATAN_Q29[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(ATAN_Q29[i]);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endfunction

  // Q60 sum to clamped output entry
  function automatic logic [15:0] matrix_entry(longint v60);
    longint lim, r;
    lim = longint'(1) <<< FRAC_BITS;
    r   = round_sh(v60, 60 - FRAC_BITS);
    if (r > lim)  r = lim;
    if (r < -lim) r = -lim;
    return r[15:0];
  endfunction

  // Q3.13 radians to hundredths of a degree, truncated toward zero and clamped at DEG_LIMIT
  function automatic logic [15:0] to_centideg(logic signed [15:0] ang);
    longint a, m, q;
    a = longint'(ang);
    m = (a < 0) ? -a : a;
    q = (m * longint'(DEG_K)) >> 32;
    if (q > longint'(DEG_LIMIT)) q = longint'(DEG_LIMIT);
    if (a < 0) q = -q;
    return q[15:0];
  endfunction

  function automatic dcm_beat_t predict_dcm(angles_t a);
    longint    sr, cr, sp, cp, sy, cy, srsp, crsp;
    dcm_beat_t d;
    cordic_sin_cos(a.roll, sr, cr);
    cordic_sin_cos(a.pitch, sp, cp);
    cordic_sin_cos(a.yaw, sy, cy);
    srsp  = round_sh(sr * sp, 30);
    crsp  = round_sh(cr * sp, 30);
    d[0]  = matrix_entry(cp * cy);
    d[1]  = matrix_entry(-(cr * sy) + srsp * cy);
    d[2]  = matrix_entry(sr * sy + crsp * cy);
    d[3]  = matrix_entry(cp * sy);
    d[4]  = matrix_entry(cr * cy + srsp * sy);
    d[5]  = matrix_entry(-(sr * cy) + crsp * sy);
    d[6]  = matrix_entry(-sp * (longint'(1) <<< 30));
    d[7]  = matrix_entry(sr * cp);
    d[8]  = matrix_entry(cr * cp);
    d[9]  = to_centideg(a.roll);
    d[10] = to_centideg(a.pitch);
    d[11] = to_centideg(a.yaw);
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one beat per queued angle set, random gap after it
  // ---------------------------------------------------------------------------
  int unsigned in_gap;
  bit          in_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap     <= 0;
      in_calm    <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      // slot is free: the current beat (if any) was just taken
      if (in_valid_i) begin
        dcm_expected.push_back(predict_dcm(angle_queue.pop_front()));
        sent_cnt <= sent_cnt + 1;
      end
      if ($urandom_range(0, 31) == 0) in_calm <= ~in_calm;
      if (in_gap != 0) begin
        in_gap     <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (angle_queue.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if ((sent_cnt + int'(in_valid_i) == pause_at_a ||
                    sent_cnt + int'(in_valid_i) == pause_at_b) &&
                   dcm_expected.size() != 0) begin
        // hold off until the pipeline has fully drained
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i    <= 1'b1;
        roll_angle_i  <= angle_queue[0].roll;
        pitch_angle_i <= angle_queue[0].pitch;
        yaw_angle_i   <= angle_queue[0].yaw;
        in_gap        <= in_calm ? 0 : $urandom_range(0, 4);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random stall after each output beat
  // ---------------------------------------------------------------------------
  int unsigned out_stall;
  bit          out_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    dcm_beat_t   got, want;
    int unsigned d;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall   <= 0;
      out_calm    <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      got = {yaw_centideg_o, pitch_centideg_o, roll_centideg_o,
             m_cz_o, m_cy_o, m_cx_o, m_bz_o, m_by_o, m_bx_o,
             m_az_o, m_ay_o, m_ax_o};
      if (dcm_expected.size() == 0) begin
        $error("output beat with no prediction waiting");
        err_cnt++;
      end else begin
        want = dcm_expected.pop_front();
        for (int i = 0; i < N_FIELDS; i++) begin
          if (got[i] !== want[i]) begin
            $error("%s: expected %0d, got %0d", field_name[i],
                   $signed(want[i]), $signed(got[i]));
            err_cnt++;
          end
        end
      end
      if ($urandom_range(0, 31) == 0) out_calm <= ~out_calm;
      d           = out_calm ? 0 : $urandom_range(0, 4);
      out_stall   <= d;
      out_ready_i <= (d == 0);
    end else if (!out_ready_i) begin
      if (out_stall <= 1) out_ready_i <= 1'b1;
      if (out_stall != 0) out_stall <= out_stall - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  function automatic logic signed [15:0] rand_angle();
    // mostly the nominal range, sometimes any 16-bit value
    if ($urandom_range(0, 9) < 7) return 16'(int'($urandom_range(0, 51472)) - 25736);
    return 16'($urandom());
  endfunction

  initial begin
    logic signed [15:0] corner [14];
    angles_t            a;
    corner = '{16'sd0, 16'sd1, -16'sd1, 16'sd12867, 16'sd12868, -16'sd12867,
               -16'sd12868, 16'sd25736, -16'sd25736, 16'sd25737, -16'sd25737,
               16'sd32767, -16'sd32768, 16'sd6434};
    // directed: every corner on at least one axis, then extreme and small sets
    for (int i = 0; i < 6; i++) angle_queue.push_back('{corner[2*i+1], corner[2*i],
                                                        corner[13-i]});
    angle_queue.push_back('{16'sd32767, 16'sd32767, 16'sd32767});
    angle_queue.push_back('{-16'sd32768, -16'sd32768, -16'sd32768});
    angle_queue.push_back('{16'sd25736, -16'sd25736, 16'sd25736});
    angle_queue.push_back('{16'sd0, 16'sd12868, 16'sd0});  // pitch near quarter turn
    angle_queue.push_back('{16'sd0, -16'sd12868, 16'sd0});
    angle_queue.push_back('{16'sd12867, 16'sd0, -16'sd12868});
    angle_queue.push_back('{-16'sd1, -16'sd1, -16'sd1});
    angle_queue.push_back('{16'sd1, 16'sd1, 16'sd1});
    angle_queue.push_back('{16'sd0, 16'sd0, 16'sd0});
    pause_at_a = angle_queue.size();
    for (int i = 0; i < N_RANDOM; i++) begin
      a.roll  = rand_angle();
      a.pitch = rand_angle();
      a.yaw   = rand_angle();
      angle_queue.push_back(a);
    end
    pause_at_b = pause_at_a + N_RANDOM / 2;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (angle_queue.size() != 0 || dcm_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (err_cnt == 0 && dcm_expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
